### src/fqsu_pkg.sv
// Shared types and constants of the FIFO queue with search and update.
// Holds request codes, status codes, sequencer states and default sizes.
// No dependencies.
package fqsu_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int WORD_W          = 32;
	localparam int REQ_W           = 3;
	localparam int STATUS_W        = 2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ    = 3'd0,
		REQ_DEQ    = 3'd1,
		REQ_SEARCH = 3'd2,
		REQ_UPDATE = 3'd3,
		REQ_REV    = 3'd4,
		REQ_READ   = 3'd5
	} req_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic {
		SQ_IDLE = 1'b0,
		SQ_WALK = 1'b1
	} seq_state_t;

endpackage

### src/fqsu_mem.sv
// Entry store of the queue: one write port, one read port with registered data.
// Depends on fqsu_pkg for the word width.
module fqsu_mem #(
	parameter int QUEUE_DEPTH = fqsu_pkg::QUEUE_DEPTH_DEF,
	parameter int IW          = $clog2(QUEUE_DEPTH)
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [IW-1:0]                   waddr,
	input  logic [fqsu_pkg::WORD_W-1:0]     wdata,
	input  logic                            re,
	input  logic [IW-1:0]                   raddr,
	output logic [fqsu_pkg::WORD_W-1:0]     rdata
);

	logic [fqsu_pkg::WORD_W-1:0] mem_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### src/fqsu_slot.sv
// Shared address unit: maps a logical position (0 = front) to its physical slot.
// Depends on fqsu_pkg only through the parameter defaults.
module fqsu_slot #(
	parameter int QUEUE_DEPTH = fqsu_pkg::QUEUE_DEPTH_DEF,
	parameter int IW          = $clog2(QUEUE_DEPTH),
	parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic [IW-1:0] front,
	input  logic [CW-1:0] count,
	input  logic          reversed,
	input  logic [CW-1:0] pos,
	output logic [IW-1:0] slot
);

	logic [CW-1:0] off;
	logic [IW:0]   sum;

	always_comb begin
		// reversed order walks down from the highest live slot
		off = reversed ? (count - CW'(1) - pos) : pos;
		sum = {1'b0, front} + (IW+1)'(off);
		if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (IW+1)'(QUEUE_DEPTH);
		end
		slot = sum[IW-1:0];
	end

endmodule

### src/fifo_queue_with_search_update.sv
// Top level of the bounded FIFO queue with search, update, reverse and read-out.
// Uses fqsu_pkg, fqsu_slot (address unit) and fqsu_mem (entry store).
//
// A request is taken at a clock edge where start is high and busy is low. Every
// request gives at least one result, shown for one cycle with result_valid high,
// the final one marked by last; the receiver cannot stall, so results must be
// taken as they come. Enqueue, reverse, unused codes and any request that meets
// an empty queue finish at once: the result shows in the next cycle and
// busy never rises, so such requests can follow each other every cycle.
// Dequeue, search, update and read-all walk the store through one address unit
// and one read port, one entry per cycle with registered read data: dequeue
// reads only the front entry, read-all reads every live entry, and search or
// update stop at the first match, reading every live entry when nothing
// matches. occupancy always shows the entry count after the latest request.
// The store is not cleared at reset; only live entries are ever read.
module fifo_queue_with_search_update #(
	parameter int QUEUE_DEPTH = fqsu_pkg::QUEUE_DEPTH_DEF,
	localparam int IW         = $clog2(QUEUE_DEPTH),
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [fqsu_pkg::REQ_W-1:0]          req_type,
	input  logic signed [fqsu_pkg::WORD_W-1:0]  value,
	input  logic signed [fqsu_pkg::WORD_W-1:0]  new_value,
	output logic                                result_valid,
	output logic [fqsu_pkg::STATUS_W-1:0]       status,
	output logic signed [fqsu_pkg::WORD_W-1:0]  data,
	output logic [CW-1:0]                       occupancy,
	output logic                                last
);

	// sequencer and queue bookkeeping
	fqsu_pkg::seq_state_t state_q, state_d;
	logic [IW-1:0]        front_q;
	logic [CW-1:0]        count_q;
	logic                 rev_q;

	// request held while walking
	fqsu_pkg::req_t               req_q;
	logic [fqsu_pkg::WORD_W-1:0]  value_q;
	logic [fqsu_pkg::WORD_W-1:0]  nval_q;

	// walk position and read stage
	logic [CW-1:0]               pos_q;
	logic                        rd_vld_s1;
	logic [CW-1:0]               rd_pos_s1;
	logic [IW-1:0]               rd_slot_s1;
	logic [fqsu_pkg::WORD_W-1:0] rdata;

	// result registers
	logic                          res_vld_q;
	logic [fqsu_pkg::STATUS_W-1:0] res_status_q;
	logic [fqsu_pkg::WORD_W-1:0]   res_data_q;
	logic                          res_last_q;

	// decoded actions
	logic                        accept;
	logic                        is_empty;
	logic                        is_full;
	logic                        emit;
	fqsu_pkg::status_t           emit_status;
	logic [fqsu_pkg::WORD_W-1:0] emit_data;
	logic                        emit_last;
	logic                        go_walk;
	logic                        enq_do;
	logic                        deq_do;
	logic                        rev_flip;
	logic                        upd_write;
	logic                        finish;
	logic                        issue;
	logic                        match;
	logic                        at_last;
	logic [CW-1:0]               lim;
	logic [CW-1:0]               slot_pos;
	logic [IW-1:0]               slot;
	logic [IW-1:0]               front_dec;
	logic [IW-1:0]               front_inc;
	logic                        mem_we;
	logic [IW-1:0]               mem_waddr;
	logic [fqsu_pkg::WORD_W-1:0] mem_wdata;

	assign busy     = (state_q != fqsu_pkg::SQ_IDLE);
	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CW'(QUEUE_DEPTH));

	// the address unit serves the enqueue slot when idle and the walk otherwise
	assign slot_pos = (state_q == fqsu_pkg::SQ_WALK) ? pos_q : count_q;

	fqsu_slot #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.IW          (IW),
		.CW          (CW)
	) u_slot (
		.front    (front_q),
		.count    (count_q),
		.reversed (rev_q),
		.pos      (slot_pos),
		.slot     (slot)
	);

	assign front_dec = (front_q == '0) ? IW'(QUEUE_DEPTH - 1) : (front_q - IW'(1));
	assign front_inc = (front_q == IW'(QUEUE_DEPTH - 1)) ? '0 : (front_q + IW'(1));

	// compare the entry that just came back from the store
	assign match   = (rdata == value_q);
	assign at_last = ((rd_pos_s1 + CW'(1)) == count_q);

	// dequeue reads only the front entry; the others may walk every live entry
	assign lim    = (req_q == fqsu_pkg::REQ_DEQ) ? CW'(1) : count_q;
	assign finish = (state_q == fqsu_pkg::SQ_WALK) && emit && emit_last;
	assign issue  = (state_q == fqsu_pkg::SQ_WALK) && (pos_q < lim) && !finish;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fqsu_pkg::SQ_IDLE: begin
				if (accept && go_walk) begin
					state_d = fqsu_pkg::SQ_WALK;
				end
			end
			fqsu_pkg::SQ_WALK: begin
				if (finish) begin
					state_d = fqsu_pkg::SQ_IDLE;
				end
			end
			default: begin
				state_d = fqsu_pkg::SQ_IDLE;
			end
		endcase
	end

	// actions and result contents
	always_comb begin
		emit        = 1'b0;
		emit_status = fqsu_pkg::ST_OK;
		emit_data   = '0;
		emit_last   = 1'b1;
		go_walk     = 1'b0;
		enq_do      = 1'b0;
		deq_do      = 1'b0;
		rev_flip    = 1'b0;
		upd_write   = 1'b0;
		unique case (state_q)
			fqsu_pkg::SQ_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					unique case (req_type)
						fqsu_pkg::REQ_ENQ: begin
							if (is_full) begin
								emit_status = fqsu_pkg::ST_FULL;
							end else begin
								enq_do = 1'b1;
							end
						end
						fqsu_pkg::REQ_DEQ, fqsu_pkg::REQ_UPDATE, fqsu_pkg::REQ_READ: begin
							if (is_empty) begin
								emit_status = fqsu_pkg::ST_EMPTY;
							end else begin
								emit    = 1'b0;
								go_walk = 1'b1;
							end
						end
						fqsu_pkg::REQ_SEARCH: begin
							if (is_empty) begin
								emit_status = fqsu_pkg::ST_NOTFOUND;
							end else begin
								emit    = 1'b0;
								go_walk = 1'b1;
							end
						end
						fqsu_pkg::REQ_REV: begin
							if (is_empty) begin
								emit_status = fqsu_pkg::ST_EMPTY;
							end else begin
								rev_flip = 1'b1;
							end
						end
						default: begin
							// unused codes: report ok and leave the queue alone
						end
					endcase
				end
			end
			fqsu_pkg::SQ_WALK: begin
				if (rd_vld_s1) begin
					unique case (req_q)
						fqsu_pkg::REQ_DEQ: begin
							emit      = 1'b1;
							emit_data = rdata;
							deq_do    = 1'b1;
						end
						fqsu_pkg::REQ_SEARCH, fqsu_pkg::REQ_UPDATE: begin
							if (match) begin
								emit      = 1'b1;
								upd_write = (req_q == fqsu_pkg::REQ_UPDATE);
							end else if (at_last) begin
								emit        = 1'b1;
								emit_status = fqsu_pkg::ST_NOTFOUND;
							end
						end
						fqsu_pkg::REQ_READ: begin
							emit      = 1'b1;
							emit_data = rdata;
							emit_last = at_last;
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// store write port: enqueue at accept, or the replacement at the end of an update
	assign mem_we    = enq_do || upd_write;
	assign mem_waddr = enq_do ? (rev_q ? front_dec : slot) : rd_slot_s1;
	assign mem_wdata = enq_do ? value : nval_q;

	fqsu_mem #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.IW          (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (slot),
		.rdata (rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fqsu_pkg::SQ_IDLE;
			front_q   <= '0;
			count_q   <= '0;
			rev_q     <= 1'b0;
			pos_q     <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			res_vld_q <= emit;
			// advance the walk one entry per issued read
			if (go_walk) begin
				pos_q <= '0;
			end else if (issue) begin
				pos_q <= pos_q + CW'(1);
			end
			// reversed order grows the rear downward through the slots
			if (enq_do) begin
				count_q <= count_q + CW'(1);
				if (rev_q) begin
					front_q <= front_dec;
				end
			end
			// reversed order drops the top slot and keeps front_q where it is
			if (deq_do) begin
				count_q <= count_q - CW'(1);
				if (!rev_q) begin
					front_q <= front_inc;
				end
			end
			if (rev_flip) begin
				rev_q <= !rev_q;
			end
		end
	end

	// payload: request fields, read stage and result contents
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= fqsu_pkg::req_t'(req_type);
			value_q <= value;
			nval_q  <= new_value;
		end
		if (issue) begin
			rd_pos_s1  <= pos_q;
			rd_slot_s1 <= slot;
		end
		if (emit) begin
			res_status_q <= emit_status;
			res_data_q   <= emit_data;
			res_last_q   <= emit_last;
		end
	end

	assign result_valid = res_vld_q;
	assign status       = res_status_q;
	assign data         = res_data_q;
	assign last         = res_last_q;
	// the count only moves on the edge that registers the final result
	assign occupancy    = count_q;

endmodule

### src/fqsu_checker.sv
// Port-level checks of the FIFO queue with search and update, bound to the top.
// Depends on fqsu_pkg for status codes and the default depth.
module fqsu_checker #(
	parameter int QUEUE_DEPTH = fqsu_pkg::QUEUE_DEPTH_DEF,
	localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               result_valid,
	input logic [fqsu_pkg::STATUS_W-1:0]      status,
	input logic [fqsu_pkg::WORD_W-1:0]        data,
	input logic [CW-1:0]                      occupancy,
	input logic                               last
);

	// an accepted item either answers at once or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> result_valid || busy)
		else $error("accepted item neither answered nor held busy");

	// a run of read-out results keeps the block busy until the final one
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("non-final result while idle");

	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> !busy)
		else $error("final result while still busy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == fqsu_pkg::ST_FULL |-> occupancy == CW'(QUEUE_DEPTH))
		else $error("full status with room left");

	a_err_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != fqsu_pkg::ST_OK |-> data == '0)
		else $error("nonzero data on a failed request");

endmodule

bind fifo_queue_with_search_update fqsu_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_fqsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.status       (status),
	.data         (data),
	.occupancy    (occupancy),
	.last         (last)
);
